// ----- hdl/tlpeq_pkg.sv -----
// tlpeq_pkg: shared types and constants of the three level priority event queue
// holds the transfer payload structs, status codes and controller/datapath bundles
// no dependencies
`default_nettype none

package tlpeq_pkg;

	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int NUM_LEVELS      = 3;
	localparam int COUNT_OUT_W     = 5;
	localparam int STORE_W         = 64;

	// priority levels
	localparam logic [1:0] LVL_HIGH   = 2'd0;
	localparam logic [1:0] LVL_MEDIUM = 2'd1;
	localparam logic [1:0] LVL_LOW    = 2'd2;
	localparam logic [1:0] LVL_NONE   = 2'd3;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXECUTE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic               op;
		logic [1:0]         level;
		logic [15:0]        device_id;
		logic signed [15:0] sensor_id;
		logic [31:0]        event_value;
	} evt_item_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [1:0]             out_level;
		logic [15:0]            out_device_id;
		logic signed [15:0]     out_sensor_id;
		logic [31:0]            out_value;
		logic [COUNT_OUT_W-1:0] high_count;
		logic [COUNT_OUT_W-1:0] medium_count;
		logic [COUNT_OUT_W-1:0] low_count;
	} res_item_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    insert;
		logic    dequeue;
		logic    emit;
		status_t status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic execute;
		logic full;
		logic pending;
	} dp_flags_t;

endpackage

`default_nettype wire

// ----- hdl/tlpeq_ram.sv -----
// tlpeq_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tlpeq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tlpeq_datapath.sv -----
// tlpeq_datapath: level pointers, counts, event store and result register
// depends on tlpeq_pkg and tlpeq_ram
`default_nettype none

module tlpeq_datapath
	import tlpeq_pkg::*;
#(
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire evt_item_t evt,
	input  wire dp_cmd_t   cmd,
	output dp_flags_t      flags,
	output res_item_t      res
);

	localparam int PTR_W  = $clog2(LEVEL_DEPTH);
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [PTR_W-1:0] head_q [NUM_LEVELS];
	logic [PTR_W-1:0] tail_q [NUM_LEVELS];
	logic [CNT_W-1:0] cnt_q  [NUM_LEVELS];

	evt_item_t        item_q;
	logic [1:0]       lvl_q;
	logic [1:0]       deq_lvl;
	logic             ram_we;
	logic             ram_re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [STORE_W-1:0] wdata;
	logic [STORE_W-1:0] rdata;
	res_item_t        res_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] l,
		input logic [PTR_W-1:0] p);
		return ADDR_W'(l) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p);
	endfunction

	// highest non-empty level wins
	always_comb begin
		priority if (cnt_q[LVL_HIGH] != '0) begin
			deq_lvl = LVL_HIGH;
		end else if (cnt_q[LVL_MEDIUM] != '0) begin
			deq_lvl = LVL_MEDIUM;
		end else begin
			deq_lvl = LVL_LOW;
		end
	end

	always_comb begin
		flags.execute = (item_q.op == OP_EXECUTE);
		flags.full    = (cnt_q[lvl_q] == CNT_W'(LEVEL_DEPTH));
		flags.pending = (cnt_q[LVL_HIGH] != '0) || (cnt_q[LVL_MEDIUM] != '0)
			|| (cnt_q[LVL_LOW] != '0);
		ram_we = cmd.insert;
		ram_re = cmd.dequeue;
		waddr  = slot_addr(lvl_q, tail_q[lvl_q]);
		raddr  = slot_addr(deq_lvl, head_q[deq_lvl]);
		wdata  = {item_q.event_value, item_q.sensor_id, item_q.device_id};
	end

	tlpeq_ram #(
		.WIDTH(STORE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (cmd.insert) begin
				tail_q[lvl_q] <= next_ptr(tail_q[lvl_q]);
				cnt_q[lvl_q]  <= cnt_q[lvl_q] + 1'b1;
			end
			if (cmd.dequeue) begin
				head_q[deq_lvl] <= next_ptr(head_q[deq_lvl]);
				cnt_q[deq_lvl]  <= cnt_q[deq_lvl] - 1'b1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= evt;
			// level three is taken as low priority
			lvl_q  <= (evt.level == LVL_NONE) ? LVL_LOW : evt.level;
		end
		if (cmd.dequeue) begin
			lvl_q <= deq_lvl;
		end
		if (cmd.emit) begin
			res_q.status       <= cmd.status;
			res_q.high_count   <= COUNT_OUT_W'(cnt_q[LVL_HIGH]);
			res_q.medium_count <= COUNT_OUT_W'(cnt_q[LVL_MEDIUM]);
			res_q.low_count    <= COUNT_OUT_W'(cnt_q[LVL_LOW]);
			if (cmd.status == ST_DEQUEUED) begin
				res_q.out_level     <= lvl_q;
				res_q.out_device_id <= rdata[15:0];
				res_q.out_sensor_id <= $signed(rdata[31:16]);
				res_q.out_value     <= rdata[63:32];
			end else begin
				res_q.out_level     <= '0;
				res_q.out_device_id <= '0;
				res_q.out_sensor_id <= '0;
				res_q.out_value     <= '0;
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ----- hdl/tlpeq_ctrl.sv -----
// tlpeq_ctrl: sequencing state machine and result valid register
// depends on tlpeq_pkg
`default_nettype none

module tlpeq_ctrl
	import tlpeq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      evt_valid,
	output logic           evt_stall,
	output logic           res_valid,
	input  wire logic      res_stall,
	input  wire dp_flags_t flags,
	output dp_cmd_t        cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_FINISH
	} state_t;

	state_t  state_q;
	status_t status_q;
	logic    valid_q;
	logic    res_free;

	assign res_free  = !valid_q || !res_stall;
	assign evt_stall = (state_q != S_IDLE);
	assign res_valid = valid_q;

	always_comb begin
		cmd.load    = (state_q == S_IDLE) && evt_valid;
		cmd.insert  = (state_q == S_DECIDE) && !flags.execute && !flags.full;
		cmd.dequeue = (state_q == S_DECIDE) && flags.execute && flags.pending;
		cmd.emit    = (state_q == S_FINISH) && res_free;
		cmd.status  = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_INSERTED;
			valid_q  <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (valid_q && !res_stall) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					priority if (flags.execute && flags.pending) begin
						status_q <= ST_DEQUEUED;
					end else if (flags.execute) begin
						status_q <= ST_EMPTY;
					end else if (flags.full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_INSERTED;
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/three_level_priority_event_queue_unit.sv -----
// three_level_priority_event_queue_unit: top level of the strict priority event queue
// depends on tlpeq_pkg, tlpeq_ctrl, tlpeq_datapath (which holds tlpeq_ram)
//
// Three bounded FIFOs of LEVEL_DEPTH events each (high, medium, low) share one
// event store ram of 3*LEVEL_DEPTH 64-bit words. An insert transfer appends the
// event to its level (level three counts as low) or reports full; an execute
// transfer pops the oldest event of the highest non-empty level or reports empty.
// Every result carries the three level counts after the step; the event fields
// are zero unless an event was dequeued. Each item passes from transfer in to
// result through the steps accept, decide (pointer update plus ram write or
// read) and finish (registered ram read data lands in the result register). The
// next item is taken the cycle after finish, so the block does not take a new
// item before it is through with the last one. A result waiting in the output
// register does not block the next input transfer; only a result that cannot
// leave the finish step holds things up. The store needs no clearing after
// reset: only written entries are ever read.
`default_nettype none

module three_level_priority_event_queue_unit
	import tlpeq_pkg::*;
#(
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	// event input channel
	input  wire logic      evt_valid,
	output logic           evt_stall,
	input  wire evt_item_t evt,
	// result channel
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res
);

	// command and status bundles between controller and datapath
	dp_cmd_t   cmd;
	dp_flags_t flags;

	// sequencing: idle, decide, finish
	tlpeq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.flags    (flags),
		.cmd      (cmd)
	);

	// pointers, counts, event store and result register
	tlpeq_datapath #(
		.LEVEL_DEPTH(LEVEL_DEPTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt),
		.cmd   (cmd),
		.flags (flags),
		.res   (res)
	);

endmodule

`default_nettype wire

// ----- test/tlpeq_checker.sv -----
// tlpeq_checker: watches both channels of the priority event queue, predicts each result
// and compares it field by field with what the block returns
// depends on tlpeq_pkg for the payload structs, level, op and status codes
module tlpeq_checker
	import tlpeq_pkg::*;
#(
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      evt_valid,
	input  wire logic      evt_stall,
	input  wire evt_item_t evt,
	input  wire logic      res_valid,
	input  wire logic      res_stall,
	input  wire res_item_t res,
	output int unsigned    mismatch_count,
	output int unsigned    awaited_count
);

	localparam int REPORT_LIMIT = 10;

	// shadow copy of the three level fifos
	evt_item_t   level_slots [NUM_LEVELS][LEVEL_DEPTH];
	int unsigned head_slot [NUM_LEVELS];
	int unsigned tail_slot [NUM_LEVELS];
	int unsigned level_fill [NUM_LEVELS];
	res_item_t   expected_results [$];
	int unsigned fail_total;

	function automatic res_item_t queue_step(input evt_item_t it);
		res_item_t r;
		evt_item_t popped;
		int lvl;
		int i;
		r = '0;
		if (it.op == OP_INSERT) begin
			lvl = (it.level == LVL_NONE) ? int'(LVL_LOW) : int'(it.level);
			if (level_fill[lvl] >= LEVEL_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				level_slots[lvl][tail_slot[lvl]] = it;
				tail_slot[lvl] = (tail_slot[lvl] + 1) % LEVEL_DEPTH;
				level_fill[lvl]++;
				r.status = ST_INSERTED;
			end
		end else begin
			// highest priority level with something waiting
			lvl = NUM_LEVELS;
			for (i = NUM_LEVELS - 1; i >= 0; i--)
				if (level_fill[i] != 0)
					lvl = i;
			if (lvl == NUM_LEVELS) begin
				r.status = ST_EMPTY;
			end else begin
				popped = level_slots[lvl][head_slot[lvl]];
				head_slot[lvl] = (head_slot[lvl] + 1) % LEVEL_DEPTH;
				level_fill[lvl]--;
				r.status        = ST_DEQUEUED;
				r.out_level     = lvl[1:0];
				r.out_device_id = popped.device_id;
				r.out_sensor_id = popped.sensor_id;
				r.out_value     = popped.event_value;
			end
		end
		r.high_count   = COUNT_OUT_W'(level_fill[LVL_HIGH]);
		r.medium_count = COUNT_OUT_W'(level_fill[LVL_MEDIUM]);
		r.low_count    = COUNT_OUT_W'(level_fill[LVL_LOW]);
		return r;
	endfunction

	function automatic string field_diffs(input res_item_t want, input res_item_t got);
		string s;
		s = "";
		if (want.status != got.status)               s = {s, " status"};
		if (want.out_level != got.out_level)         s = {s, " out_level"};
		if (want.out_device_id != got.out_device_id) s = {s, " out_device_id"};
		if (want.out_sensor_id != got.out_sensor_id) s = {s, " out_sensor_id"};
		if (want.out_value != got.out_value)         s = {s, " out_value"};
		if (want.high_count != got.high_count)       s = {s, " high_count"};
		if (want.medium_count != got.medium_count)   s = {s, " medium_count"};
		if (want.low_count != got.low_count)         s = {s, " low_count"};
		return s;
	endfunction

	function automatic string fmt_result(input res_item_t r);
		return $sformatf("st=%0d lvl=%0d dev=%04h sen=%0d val=%08h cnt=%0d/%0d/%0d",
			r.status, r.out_level, r.out_device_id, r.out_sensor_id, r.out_value,
			r.high_count, r.medium_count, r.low_count);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_item_t oldest;
		string diffs;
		int l;
		if (!arst_n) begin
			for (l = 0; l < NUM_LEVELS; l++) begin
				head_slot[l]  = 0;
				tail_slot[l]  = 0;
				level_fill[l] = 0;
			end
			expected_results.delete();
			fail_total = 0;
			mismatch_count <= 0;
			awaited_count  <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_total < REPORT_LIMIT)
						$display("%0t: result with nothing expected: %s", $realtime,
							fmt_result(res));
					fail_total++;
				end else begin
					oldest = expected_results.pop_front();
					diffs  = field_diffs(oldest, res);
					if (diffs != "") begin
						if (fail_total < REPORT_LIMIT)
							$display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
								$realtime, diffs, fmt_result(oldest), fmt_result(res));
						fail_total++;
					end
				end
			end
			if (evt_valid && !evt_stall)
				expected_results.push_back(queue_step(evt));
			mismatch_count <= fail_total;
			awaited_count  <= expected_results.size();
		end
	end

endmodule

// ----- test/tb_three_level_priority_event_queue_unit.sv -----
// tb_three_level_priority_event_queue_unit: stimulus and verdict for the priority event queue
// drives insert and execute transfers with random gaps and result stalls, checking is done
// by tlpeq_checker; depends on tlpeq_pkg and three_level_priority_event_queue_unit
module tb_three_level_priority_event_queue_unit;
	import tlpeq_pkg::*;

	localparam int QUEUE_DEPTH  = LEVEL_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1350;
	// no idling on either side for this window of random items
	localparam int STEADY_FIRST = 500;
	localparam int STEADY_LAST  = 800;
	localparam int IDLE_PCT     = 13;
	// idle tail run after the last expected result has been seen
	localparam int DRAIN_CYCLES = 12;
	// worst case for the ~1400 items of the run is far below this
	localparam int CYCLE_LIMIT  = 300000;

	logic        clk;
	logic        arst_n;
	logic        evt_valid;
	logic        evt_stall;
	evt_item_t   evt;
	logic        res_valid;
	logic        res_stall;
	res_item_t   res;
	logic        steady;
	int unsigned mismatch_count;
	int unsigned awaited_count;
	int unsigned cycle_count;

	three_level_priority_event_queue_unit #(
		.LEVEL_DEPTH(QUEUE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	tlpeq_checker #(
		.LEVEL_DEPTH(QUEUE_DEPTH)
	) u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (evt_valid),
		.evt_stall     (evt_stall),
		.evt           (evt),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res           (res),
		.mismatch_count(mismatch_count),
		.awaited_count (awaited_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("three_level_priority_event_queue_unit verification failed");
			$finish;
		end
	end

	// result side back-pressure, changes only on the falling edge
	always @(negedge clk) begin
		res_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
	end

	function automatic evt_item_t make_evt(input op_t op, input logic [1:0] lvl,
		input logic [15:0] dev, input logic [15:0] sen, input logic [31:0] val);
		evt_item_t it;
		it.op          = op;
		it.level       = lvl;
		it.device_id   = dev;
		it.sensor_id   = sen;
		it.event_value = val;
		return it;
	endfunction

	// sensor ids lean on no-sensor and the range ends, rest uniform over 16 bits
	function automatic logic [15:0] rand_sensor();
		case ($urandom_range(0, 9))
			0:       return 16'hffff;
			1:       return 16'h7fff;
			2:       return 16'h8000;
			3:       return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 15))
			0:       return 32'h0000_0000;
			1:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send(input evt_item_t it);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			evt_valid <= 1'b0;
			@(negedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= it;
		// payload holds until the transfer edge
		do
			@(posedge clk);
		while (evt_stall);
		@(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned item_total;
		int unsigned insert_pct;
		int unsigned run_len;
		logic [1:0]  favored;
		logic [1:0]  lvl;

		evt_valid   = 1'b0;
		evt         = '0;
		steady      = 1'b0;
		arst_n      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: execute on an empty queue
		send(make_evt(OP_EXECUTE, LVL_HIGH, 16'h0000, 16'h0000, 32'h0));
		// level three lands in the low fifo, all-ones fields
		send(make_evt(OP_INSERT, LVL_NONE, 16'hffff, 16'hffff, 32'hffff_ffff));
		send(make_evt(OP_INSERT, LVL_MEDIUM, 16'h0000, 16'h7fff, 32'h0000_0000));
		send(make_evt(OP_INSERT, LVL_HIGH, 16'h5a5a, 16'h0000, 32'h8000_0001));
		// fill the low fifo to capacity, then one more to see it refused
		repeat (QUEUE_DEPTH - 1)
			send(make_evt(OP_INSERT, LVL_LOW, 16'($urandom), rand_sensor(), rand_value()));
		send(make_evt(OP_INSERT, LVL_LOW, 16'ha5a5, 16'h8000, 32'h0000_0001));
		// strict priority: high, then medium, then the oldest low
		repeat (3)
			send(make_evt(OP_EXECUTE, 2'($urandom), 16'($urandom), rand_sensor(),
				rand_value()));

		// random runs alternate between filling, draining and mixed traffic so the
		// fifos keep crossing full and empty; each run leans toward one level
		item_total = 0;
		while (item_total < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       insert_pct = 80;
				1:       insert_pct = 25;
				default: insert_pct = 55;
			endcase
			run_len = $urandom_range(20, 80);
			favored = 2'($urandom);
			repeat (run_len) begin
				steady = (item_total >= STEADY_FIRST) && (item_total < STEADY_LAST);
				lvl    = $urandom_range(0, 1) ? favored : 2'($urandom);
				if ($urandom_range(0, 99) < insert_pct)
					send(make_evt(OP_INSERT, lvl, 16'($urandom), rand_sensor(),
						rand_value()));
				else
					send(make_evt(OP_EXECUTE, lvl, 16'($urandom), rand_sensor(),
						rand_value()));
				item_total++;
			end
		end
		evt_valid <= 1'b0;
		steady = 1'b0;

		// every transfer gives a result, so wait for the last one, then a short tail
		while (awaited_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && awaited_count == 0)
			$display("three_level_priority_event_queue_unit verification clean");
		else
			$display("three_level_priority_event_queue_unit verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/tlpeq_pkg.sv
hdl/tlpeq_ram.sv
hdl/tlpeq_datapath.sv
hdl/tlpeq_ctrl.sv
hdl/three_level_priority_event_queue_unit.sv
test/tlpeq_checker.sv
test/tb_three_level_priority_event_queue_unit.sv
